>>> design/motion_command_safety_gate_assert.svh
// assertion macros for the motion command safety gate
`ifndef MOTION_COMMAND_SAFETY_GATE_ASSERT_SVH
`define MOTION_COMMAND_SAFETY_GATE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSCG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define MSCG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> design/mscg_pkg.sv
// types, constants and limit functions for the motion command safety gate
`default_nettype none
package mscg_pkg;

	localparam int VALUE_BITS   = 16;
	localparam int LIMIT_BITS   = 15;
	localparam int TIMEOUT_BITS = 16;
	localparam int AGE_BITS_DEF = 16;
	localparam int APB_ADDR_BITS = 5;
	localparam int APB_DATA_BITS = 32;
	localparam int NUM_SOURCES  = 4;

	typedef enum logic [2:0] {
		KIND_BASE      = 3'd0,
		KIND_GIMBAL    = 3'd1,
		KIND_PLATFORM  = 3'd2,
		KIND_REFERENCE = 3'd3,
		KIND_TICK      = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		REG_RAW_TIMEOUT      = 3'd0,
		REG_REF_TIMEOUT      = 3'd1,
		REG_PLATFORM_TIMEOUT = 3'd2,
		REG_LIMIT_FORWARD    = 3'd3,
		REG_LIMIT_SIDE       = 3'd4,
		REG_LIMIT_TURN       = 3'd5,
		REG_LIMIT_YAW        = 3'd6,
		REG_LIMIT_PITCH      = 3'd7
	} reg_index_t;

	localparam logic [TIMEOUT_BITS-1:0] RAW_TIMEOUT_RST      = 16'd12;
	localparam logic [TIMEOUT_BITS-1:0] REF_TIMEOUT_RST      = 16'd25;
	localparam logic [TIMEOUT_BITS-1:0] PLATFORM_TIMEOUT_RST = 16'd25;
	localparam logic [LIMIT_BITS-1:0]   LIMIT_FORWARD_RST    = 15'd3277;
	localparam logic [LIMIT_BITS-1:0]   LIMIT_SIDE_RST       = 15'd2048;
	localparam logic [LIMIT_BITS-1:0]   LIMIT_TURN_RST       = 15'd4915;
	localparam logic [LIMIT_BITS-1:0]   LIMIT_YAW_RST        = 15'd6144;
	localparam logic [LIMIT_BITS-1:0]   LIMIT_PITCH_RST      = 15'd4096;

	typedef logic signed [VALUE_BITS-1:0] value_t;

	typedef struct packed {
		logic [2:0] kind;
		value_t     first_value;
		value_t     second_value;
		value_t     third_value;
		value_t     fourth_value;
		logic       first_flag;
		logic       second_flag;
		logic       third_flag;
	} item_t;

	typedef struct packed {
		value_t out_forward_speed;
		value_t out_side_speed;
		value_t out_turn_rate;
		value_t out_yaw_rate;
		value_t out_pitch_rate;
		logic   out_hold_yaw;
		logic   out_hold_pitch;
		logic   safe_stop;
	} result_t;

	typedef struct packed {
		logic [TIMEOUT_BITS-1:0] raw_timeout_ticks;
		logic [TIMEOUT_BITS-1:0] reference_timeout_ticks;
		logic [TIMEOUT_BITS-1:0] platform_timeout_ticks;
		logic [LIMIT_BITS-1:0]   limit_forward_speed;
		logic [LIMIT_BITS-1:0]   limit_side_speed;
		logic [LIMIT_BITS-1:0]   limit_base_turn_rate;
		logic [LIMIT_BITS-1:0]   limit_gimbal_yaw_rate;
		logic [LIMIT_BITS-1:0]   limit_gimbal_pitch_rate;
	} cfg_t;

	// lesser of the configured limit and a positive reference limit, when use_ref is set
	function automatic logic [LIMIT_BITS-1:0] eff_limit(
		input logic [LIMIT_BITS-1:0] cfg_lim,
		input value_t                ref_lim,
		input logic                  use_ref
	);
		logic [LIMIT_BITS-1:0] lim;
		lim = cfg_lim;
		if (use_ref && (ref_lim > 0) && (ref_lim < $signed({1'b0, cfg_lim})))
			lim = ref_lim[LIMIT_BITS-1:0];
		return lim;
	endfunction

	// symmetric clamp to +/- lim
	function automatic value_t clamp_sym(
		input value_t                v,
		input logic [LIMIT_BITS-1:0] lim
	);
		logic signed [VALUE_BITS:0] vw;
		logic signed [VALUE_BITS:0] lw;
		logic signed [VALUE_BITS:0] nl;
		value_t                     r;
		vw = {v[VALUE_BITS-1], v};
		lw = {2'b00, lim};
		nl = -lw;
		if (vw > lw)
			r = lw[VALUE_BITS-1:0];
		else if (vw < nl)
			r = nl[VALUE_BITS-1:0];
		else
			r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/motion_command_safety_gate.sv
// top level of the motion command safety gate: source store, ages, gating and clamping
//
// channel   dir  handshake                  beat
// item      in   item_valid / item_ready    item_t: one source update or a tick
// result    out  result_valid / result_ready result_t: one command per tick
// apb       in   psel / penable / pready    8 configuration registers at 4*i
//
// one beat accepted per cycle while a tick beat is not stalled; each beat passes through the input register
// a tick beat goes from the input register into the result register
// source beats update state only, unused-kind beats are dropped, and neither gives a result
// reset clears valids, seen flags and ages; config returns to defaults
// a waiting result stalls input only when the next beat in line is a tick
`default_nettype none
module motion_command_safety_gate
	import mscg_pkg::*;
#(
	parameter int AGE_BITS = AGE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_ready,
	input  wire item_t                    item,
	output logic                          result_valid,
	input  wire logic                     result_ready,
	output result_t                       result,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready
);

	`include "motion_command_safety_gate_assert.svh"

	localparam int CMP_BITS = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;

	localparam logic [1:0] SRC_BASE      = 2'(KIND_BASE);
	localparam logic [1:0] SRC_GIMBAL    = 2'(KIND_GIMBAL);
	localparam logic [1:0] SRC_PLATFORM  = 2'(KIND_PLATFORM);
	localparam logic [1:0] SRC_REFERENCE = 2'(KIND_REFERENCE);

	cfg_t cfg;

	mscg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	logic                valid_s1;
	item_t               item_s1;
	logic                is_tick;
	logic                adv;
	logic                result_valid_q;
	result_t             result_q;
	result_t             res_d;

	logic [NUM_SOURCES-1:0] seen_q;
	logic [AGE_BITS-1:0]    age_q   [NUM_SOURCES];
	logic [AGE_BITS-1:0]    age_inc [NUM_SOURCES];
	value_t                 base_q  [3];
	value_t                 gimbal_q[2];
	logic [1:0]             holds_q;
	logic                   estop_q;
	logic [2:0]             ref_flags_q;
	value_t                 ref_lim_q[4];

	logic fresh_base, fresh_gimbal, fresh_plat, fresh_ref;
	logic plat_ok, ref_ok;

	assign is_tick      = (item_s1.kind == KIND_TICK);
	assign adv          = valid_s1 && (!is_tick || !result_valid_q || result_ready);
	assign item_ready   = !valid_s1 || adv;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		for (int i = 0; i < NUM_SOURCES; i++) begin
			age_inc[i] = (age_q[i] == '1) ? age_q[i] : age_q[i] + AGE_BITS'(1);
		end
	end

	assign fresh_base   = seen_q[SRC_BASE] &&
		(CMP_BITS'(age_inc[SRC_BASE]) <= CMP_BITS'(cfg.raw_timeout_ticks));
	assign fresh_gimbal = seen_q[SRC_GIMBAL] &&
		(CMP_BITS'(age_inc[SRC_GIMBAL]) <= CMP_BITS'(cfg.raw_timeout_ticks));
	assign fresh_plat   = seen_q[SRC_PLATFORM] &&
		(CMP_BITS'(age_inc[SRC_PLATFORM]) <= CMP_BITS'(cfg.platform_timeout_ticks));
	assign fresh_ref    = seen_q[SRC_REFERENCE] &&
		(CMP_BITS'(age_inc[SRC_REFERENCE]) <= CMP_BITS'(cfg.reference_timeout_ticks));
	assign plat_ok      = fresh_plat && !estop_q;
	assign ref_ok       = fresh_ref && ref_flags_q[0];

	always_comb begin
		res_d = '0;
		res_d.out_hold_yaw   = 1'b1;
		res_d.out_hold_pitch = 1'b1;
		if (!plat_ok || !ref_ok) begin
			res_d.safe_stop = 1'b1;
		end else begin
			if (fresh_base && ref_flags_q[1]) begin
				res_d.out_forward_speed = clamp_sym(base_q[0],
					eff_limit(cfg.limit_forward_speed, ref_lim_q[0], 1'b1));
				res_d.out_side_speed    = clamp_sym(base_q[1],
					eff_limit(cfg.limit_side_speed, ref_lim_q[0], 1'b0));
				res_d.out_turn_rate     = clamp_sym(base_q[2],
					eff_limit(cfg.limit_base_turn_rate, ref_lim_q[1], 1'b1));
			end
			if (fresh_gimbal && ref_flags_q[2]) begin
				res_d.out_yaw_rate   = clamp_sym(gimbal_q[0],
					eff_limit(cfg.limit_gimbal_yaw_rate, ref_lim_q[2], 1'b1));
				res_d.out_pitch_rate = clamp_sym(gimbal_q[1],
					eff_limit(cfg.limit_gimbal_pitch_rate, ref_lim_q[3], 1'b1));
				res_d.out_hold_yaw   = holds_q[0];
				res_d.out_hold_pitch = holds_q[1];
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// seen flags and ages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < NUM_SOURCES; i++) begin
				age_q[i] <= '0;
			end
		end else if (adv) begin
			if (is_tick) begin
				for (int i = 0; i < NUM_SOURCES; i++) begin
					age_q[i] <= age_inc[i];
				end
			end else if (item_s1.kind < KIND_TICK) begin
				seen_q[item_s1.kind[1:0]] <= 1'b1;
				age_q[item_s1.kind[1:0]]  <= '0;
			end
		end
	end

	// stored source payloads, only read once the source is seen
	always_ff @(posedge clk) begin
		if (adv) begin
			case (item_s1.kind)
				KIND_BASE: begin
					base_q[0] <= item_s1.first_value;
					base_q[1] <= item_s1.second_value;
					base_q[2] <= item_s1.third_value;
				end
				KIND_GIMBAL: begin
					gimbal_q[0] <= item_s1.first_value;
					gimbal_q[1] <= item_s1.second_value;
					holds_q     <= {item_s1.second_flag, item_s1.first_flag};
				end
				KIND_PLATFORM: begin
					estop_q <= item_s1.first_flag;
				end
				KIND_REFERENCE: begin
					ref_lim_q[0] <= item_s1.first_value;
					ref_lim_q[1] <= item_s1.second_value;
					ref_lim_q[2] <= item_s1.third_value;
					ref_lim_q[3] <= item_s1.fourth_value;
					ref_flags_q  <= {item_s1.third_flag, item_s1.second_flag, item_s1.first_flag};
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && is_tick) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_tick) begin
			result_q <= res_d;
		end
	end

	`MSCG_ASSERT_NOW(a_stop_is_zero, result_valid_q && result_q.safe_stop,
		(result_q.out_forward_speed == 0) && (result_q.out_side_speed == 0) &&
		(result_q.out_turn_rate == 0) && (result_q.out_yaw_rate == 0) &&
		(result_q.out_pitch_rate == 0) && result_q.out_hold_yaw && result_q.out_hold_pitch)
	`MSCG_ASSERT_NOW(a_side_in_limit, result_valid_q,
		($signed({result_q.out_side_speed[VALUE_BITS-1], result_q.out_side_speed}) <=
		$signed({2'b00, cfg.limit_side_speed})) &&
		($signed({result_q.out_side_speed[VALUE_BITS-1], result_q.out_side_speed}) >=
		-$signed({2'b00, cfg.limit_side_speed})))
	`MSCG_ASSERT_NEXT(a_no_result_from_source, valid_s1 && !is_tick && !result_valid_q,
		!result_valid_q)
	`MSCG_ASSERT_NEXT(a_seen_sticky, 1'b1, (seen_q & $past(seen_q)) == $past(seen_q))

endmodule
`default_nettype wire

>>> design/mscg_regs.sv
// apb configuration registers for the motion command safety gate
`default_nettype none
module mscg_regs
	import mscg_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready,
	output cfg_t                          cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	reg_index_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_index_t'(paddr[APB_ADDR_BITS-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_timeout_ticks       <= RAW_TIMEOUT_RST;
			cfg_q.reference_timeout_ticks <= REF_TIMEOUT_RST;
			cfg_q.platform_timeout_ticks  <= PLATFORM_TIMEOUT_RST;
			cfg_q.limit_forward_speed     <= LIMIT_FORWARD_RST;
			cfg_q.limit_side_speed        <= LIMIT_SIDE_RST;
			cfg_q.limit_base_turn_rate    <= LIMIT_TURN_RST;
			cfg_q.limit_gimbal_yaw_rate   <= LIMIT_YAW_RST;
			cfg_q.limit_gimbal_pitch_rate <= LIMIT_PITCH_RST;
		end else if (wr_en) begin
			case (idx)
				REG_RAW_TIMEOUT:      cfg_q.raw_timeout_ticks       <= pwdata[TIMEOUT_BITS-1:0];
				REG_REF_TIMEOUT:      cfg_q.reference_timeout_ticks <= pwdata[TIMEOUT_BITS-1:0];
				REG_PLATFORM_TIMEOUT: cfg_q.platform_timeout_ticks  <= pwdata[TIMEOUT_BITS-1:0];
				REG_LIMIT_FORWARD:    cfg_q.limit_forward_speed     <= pwdata[LIMIT_BITS-1:0];
				REG_LIMIT_SIDE:       cfg_q.limit_side_speed        <= pwdata[LIMIT_BITS-1:0];
				REG_LIMIT_TURN:       cfg_q.limit_base_turn_rate    <= pwdata[LIMIT_BITS-1:0];
				REG_LIMIT_YAW:        cfg_q.limit_gimbal_yaw_rate   <= pwdata[LIMIT_BITS-1:0];
				REG_LIMIT_PITCH:      cfg_q.limit_gimbal_pitch_rate <= pwdata[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RAW_TIMEOUT:      prdata = APB_DATA_BITS'(cfg_q.raw_timeout_ticks);
			REG_REF_TIMEOUT:      prdata = APB_DATA_BITS'(cfg_q.reference_timeout_ticks);
			REG_PLATFORM_TIMEOUT: prdata = APB_DATA_BITS'(cfg_q.platform_timeout_ticks);
			REG_LIMIT_FORWARD:    prdata = APB_DATA_BITS'(cfg_q.limit_forward_speed);
			REG_LIMIT_SIDE:       prdata = APB_DATA_BITS'(cfg_q.limit_side_speed);
			REG_LIMIT_TURN:       prdata = APB_DATA_BITS'(cfg_q.limit_base_turn_rate);
			REG_LIMIT_YAW:        prdata = APB_DATA_BITS'(cfg_q.limit_gimbal_yaw_rate);
			REG_LIMIT_PITCH:      prdata = APB_DATA_BITS'(cfg_q.limit_gimbal_pitch_rate);
			default:              prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the motion command safety gate
module tb_top;
	import mscg_pkg::*;

	typedef enum int {
		PROFILE_RANDOM,
		PROFILE_WIDE,
		PROFILE_TIGHT,
		PROFILE_CLOSED
	} cfg_profile_e;

	localparam logic [2:0] KIND_FIRST_UNUSED = KIND_TICK + 3'd1;
	localparam int NUM_REGS = 8;
	localparam int CHUNK_ITEMS = 104;

	class gate_command_predictor;
		localparam int unsigned AGE_LIMIT = (1 << AGE_BITS_DEF) - 1;

		logic [15:0] reg_val [NUM_REGS];
		logic [3:0] seen;
		int unsigned age [NUM_SOURCES];
		int base_motion [3];
		int gimbal_rate [2];
		logic gimbal_yaw_hold;
		logic gimbal_pitch_hold;
		logic estop;
		logic ref_valid;
		logic base_enabled;
		logic gimbal_enabled;
		int ref_limit [4];
		result_t expected_commands [$];
		int mismatch_count;

		function new();
			reg_val[REG_RAW_TIMEOUT] = RAW_TIMEOUT_RST;
			reg_val[REG_REF_TIMEOUT] = REF_TIMEOUT_RST;
			reg_val[REG_PLATFORM_TIMEOUT] = PLATFORM_TIMEOUT_RST;
			reg_val[REG_LIMIT_FORWARD] = LIMIT_FORWARD_RST;
			reg_val[REG_LIMIT_SIDE] = LIMIT_SIDE_RST;
			reg_val[REG_LIMIT_TURN] = LIMIT_TURN_RST;
			reg_val[REG_LIMIT_YAW] = LIMIT_YAW_RST;
			reg_val[REG_LIMIT_PITCH] = LIMIT_PITCH_RST;
			seen = '0;
			gimbal_yaw_hold = 1'b0;
			gimbal_pitch_hold = 1'b0;
			estop = 1'b0;
			ref_valid = 1'b0;
			base_enabled = 1'b0;
			gimbal_enabled = 1'b0;
			mismatch_count = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [31:0] data);
			if (idx <= REG_PLATFORM_TIMEOUT)
				reg_val[idx] = data[15:0];
			else
				reg_val[idx] = {1'b0, data[14:0]};
		endfunction

		function bit fresh(int src, int unsigned timeout);
			return seen[src] && (age[src] <= timeout);
		endfunction

		function int limit_of(reg_index_t idx, int ref_lim, bit use_ref);
			int lim;
			lim = reg_val[idx];
			if (use_ref && ref_lim > 0 && ref_lim < lim)
				lim = ref_lim;
			return lim;
		endfunction

		function value_t clamp_to(int v, int lim);
			int r;
			r = v;
			if (v > lim)
				r = lim;
			else if (v < -lim)
				r = -lim;
			return value_t'(r);
		endfunction

		function void note_item(item_t it);
			result_t cmd;
			bit plat_ok;
			bit ref_ok;
			case (it.kind)
				KIND_BASE: begin
					base_motion[0] = it.first_value;
					base_motion[1] = it.second_value;
					base_motion[2] = it.third_value;
				end
				KIND_GIMBAL: begin
					gimbal_rate[0] = it.first_value;
					gimbal_rate[1] = it.second_value;
					gimbal_yaw_hold = it.first_flag;
					gimbal_pitch_hold = it.second_flag;
				end
				KIND_PLATFORM: estop = it.first_flag;
				KIND_REFERENCE: begin
					ref_limit[0] = it.first_value;
					ref_limit[1] = it.second_value;
					ref_limit[2] = it.third_value;
					ref_limit[3] = it.fourth_value;
					ref_valid = it.first_flag;
					base_enabled = it.second_flag;
					gimbal_enabled = it.third_flag;
				end
				KIND_TICK: ;
				default: return;
			endcase
			if (it.kind != KIND_TICK) begin
				seen[it.kind] = 1'b1;
				age[it.kind] = 0;
				return;
			end
			foreach (age[i])
				if (age[i] < AGE_LIMIT)
					age[i]++;
			cmd = '0;
			cmd.out_hold_yaw = 1'b1;
			cmd.out_hold_pitch = 1'b1;
			plat_ok = fresh(KIND_PLATFORM, reg_val[REG_PLATFORM_TIMEOUT]) && !estop;
			ref_ok = fresh(KIND_REFERENCE, reg_val[REG_REF_TIMEOUT]) && ref_valid;
			if (!(plat_ok && ref_ok)) begin
				cmd.safe_stop = 1'b1;
			end else begin
				if (fresh(KIND_BASE, reg_val[REG_RAW_TIMEOUT]) && base_enabled) begin
					cmd.out_forward_speed = clamp_to(base_motion[0],
						limit_of(REG_LIMIT_FORWARD, ref_limit[0], 1'b1));
					cmd.out_side_speed = clamp_to(base_motion[1],
						limit_of(REG_LIMIT_SIDE, 0, 1'b0));
					cmd.out_turn_rate = clamp_to(base_motion[2],
						limit_of(REG_LIMIT_TURN, ref_limit[1], 1'b1));
				end
				if (fresh(KIND_GIMBAL, reg_val[REG_RAW_TIMEOUT]) && gimbal_enabled) begin
					cmd.out_yaw_rate = clamp_to(gimbal_rate[0],
						limit_of(REG_LIMIT_YAW, ref_limit[2], 1'b1));
					cmd.out_pitch_rate = clamp_to(gimbal_rate[1],
						limit_of(REG_LIMIT_PITCH, ref_limit[3], 1'b1));
					cmd.out_hold_yaw = gimbal_yaw_hold;
					cmd.out_hold_pitch = gimbal_pitch_hold;
				end
			end
			expected_commands.push_back(cmd);
		endfunction

		function string show(result_t r);
			return $sformatf("fwd %0d side %0d turn %0d yaw %0d pitch %0d hold %b%b stop %b",
				r.out_forward_speed, r.out_side_speed, r.out_turn_rate, r.out_yaw_rate,
				r.out_pitch_rate, r.out_hold_yaw, r.out_hold_pitch, r.safe_stop);
		endfunction

		function void flag(string what);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%s", what);
		endfunction

		function void check_command(result_t got);
			result_t want;
			if (expected_commands.size() == 0) begin
				flag({"command beat with none expected: ", show(got)});
				return;
			end
			want = expected_commands.pop_front();
			if (got.out_forward_speed !== want.out_forward_speed ||
				got.out_side_speed !== want.out_side_speed ||
				got.out_turn_rate !== want.out_turn_rate ||
				got.out_yaw_rate !== want.out_yaw_rate ||
				got.out_pitch_rate !== want.out_pitch_rate ||
				got.out_hold_yaw !== want.out_hold_yaw ||
				got.out_hold_pitch !== want.out_hold_pitch ||
				got.safe_stop !== want.safe_stop)
				flag($sformatf("command mismatch at %0t\n  expected %s\n  actual   %s",
					$realtime, show(want), show(got)));
		endfunction

		function int pending();
			return expected_commands.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	gate_command_predictor pred = new();
	int send_idle_pct = 11;
	int recv_idle_pct = 47;
	int hold_left = 0;

	motion_command_safety_gate uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				pred.note_item(item);
			if (result_valid && result_ready)
				pred.check_command(result);
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic item_t make_item(logic [2:0] kind, int a, int b, int c, int d,
		logic f1, logic f2, logic f3);
		item_t it;
		it.kind = kind;
		it.first_value = value_t'(a);
		it.second_value = value_t'(b);
		it.third_value = value_t'(c);
		it.fourth_value = value_t'(d);
		it.first_flag = f1;
		it.second_flag = f2;
		it.third_flag = f3;
		return it;
	endfunction

	function automatic int modest_value();
		int v;
		v = $urandom_range(16000);
		return v - 8000;
	endfunction

	function automatic int motion_value();
		if ($urandom_range(1))
			return modest_value();
		return $urandom;
	endfunction

	function automatic int ref_limit_value();
		int pick;
		pick = $urandom_range(9);
		if (pick < 4)
			return $urandom_range(8000, 1);
		if (pick < 6)
			return -$urandom_range(100);
		return $urandom;
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		it = make_item(KIND_TICK, $urandom, $urandom, $urandom, $urandom,
			$urandom_range(1), $urandom_range(1), $urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 38) begin
			it.kind = KIND_TICK;
		end else if (pick < 56) begin
			it.kind = KIND_BASE;
			it.first_value = value_t'(motion_value());
			it.second_value = value_t'(motion_value());
			it.third_value = value_t'(motion_value());
		end else if (pick < 70) begin
			it.kind = KIND_GIMBAL;
			it.first_value = value_t'(motion_value());
			it.second_value = value_t'(motion_value());
		end else if (pick < 78) begin
			it.kind = KIND_PLATFORM;
			it.first_flag = ($urandom_range(99) < 12);
		end else if (pick < 90) begin
			it.kind = KIND_REFERENCE;
			it.first_value = value_t'(ref_limit_value());
			it.second_value = value_t'(ref_limit_value());
			it.third_value = value_t'(ref_limit_value());
			it.fourth_value = value_t'(ref_limit_value());
			it.first_flag = ($urandom_range(99) < 88);
			it.second_flag = ($urandom_range(99) < 80);
			it.third_flag = ($urandom_range(99) < 80);
		end else if (pick < 95) begin
			it.kind = KIND_FIRST_UNUSED + 3'($urandom_range(2));
		end else begin
			it.kind = KIND_TICK;
		end
		return it;
	endfunction

	task automatic drive_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		pred.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pred.pending() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic configure(input cfg_profile_e profile);
		reg_index_t idx;
		logic [31:0] data;
		bit is_timeout;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = reg_index_t'(i);
			is_timeout = (idx <= REG_PLATFORM_TIMEOUT);
			case (profile)
				PROFILE_RANDOM:
					data = is_timeout ? {16'($urandom), 16'($urandom_range(40))} : $urandom;
				PROFILE_WIDE:
					data = 32'hFFFF_FFFF;
				PROFILE_TIGHT:
					data = !is_timeout ? 32'd0 : (idx == REG_RAW_TIMEOUT) ? 32'd1 : 32'd3;
				default:
					data = is_timeout ? 32'd0 : $urandom_range(100);
			endcase
			write_reg(idx, data);
		end
	endtask

	initial begin
		cfg_profile_e chunk_profile [6];
		chunk_profile = '{PROFILE_RANDOM, PROFILE_WIDE, PROFILE_TIGHT,
			PROFILE_RANDOM, PROFILE_CLOSED, PROFILE_RANDOM};
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		result_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats under reset limits
		drive_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_item(KIND_PLATFORM, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_item(KIND_REFERENCE, 32767, 32767, 32767, 32767, 1, 1, 1));
		drive_item(make_item(KIND_BASE, 32767, -32768, 32767, -1, 0, 0, 0));
		drive_item(make_item(KIND_GIMBAL, -32768, 32767, 0, 0, 1, 0, 0));
		drive_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_item(KIND_REFERENCE, 100, 0, -5, -32768, 1, 1, 1));
		drive_item(make_item(KIND_BASE, -32768, 0, -32768, 0, 1, 1, 1));
		drive_item(make_item(KIND_GIMBAL, 50, -50, 0, 0, 0, 1, 0));
		drive_item(make_item(KIND_TICK, -1, -1, -1, -1, 1, 1, 1));
		for (int k = 0; k < 3; k++)
			drive_item(make_item(KIND_FIRST_UNUSED + 3'(k), -1, -1, -1, -1, 1, 1, 1));
		drive_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_item(KIND_PLATFORM, 0, 0, 0, 0, 1, 0, 0));
		drive_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_item(KIND_PLATFORM, 0, 0, 0, 0, 0, 1, 1));
		drive_item(make_item(KIND_REFERENCE, 1, 1, 1, 1, 0, 1, 1));
		drive_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_item(KIND_REFERENCE, 1, 1, 1, 1, 1, 0, 0));
		drive_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		drive_item(make_item(KIND_REFERENCE, 1, 1, 1, 1, 1, 1, 1));
		drive_item(make_item(KIND_TICK, 0, 0, 0, 0, 0, 0, 0));
		drain();

		for (int c = 0; c < 6; c++) begin
			send_idle_pct = (c < 2) ? 11 : (c < 4) ? 47 : 0;
			recv_idle_pct = (c < 2) ? 47 : (c < 4) ? 11 : 0;
			configure(chunk_profile[c]);
			for (int n = 0; n < CHUNK_ITEMS; n++) begin
				if (c == 1 && n == 30)
					hold_left = 300;
				drive_item(random_item());
			end
			drain();
		end

		if (pred.mismatch_count == 0 && pred.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
